// ===== rtl/rhht_pkg.sv =====
// ----------------------------------------------------------------------------
// rhht_pkg: shared constants and a helper for the robin hood hash table
// Opcodes, status codes and the DJB2 home-slot hash.
// ----------------------------------------------------------------------------
`default_nettype none
package rhht_pkg;
    localparam int unsigned SLOTS_DEF  = 256;
    localparam logic [31:0] HASH_SEED  = 32'd5381;
    localparam logic [7:0]  DIST_CAP   = 8'd254;
    localparam logic [7:0]  LIMIT_RST  = 8'd8;

    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // djb2 over four bytes, low byte first; h*33 is a shift and add
    function automatic logic [31:0] djb2(input logic [31:0] key);
        logic [31:0] h;
        h = HASH_SEED;
        for (int i = 0; i < 4; i++) begin
            h = (h << 5) + h + {24'd0, key[8*i +: 8]};
        end
        return h;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/robin_hood_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// robin_hood_hash_table_unit: robin hood hash table with backward-shift delete
// One slot memory, one slot probed per read/modify/write step.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata fields (low bit first)
//  s_axis   | in  | opcode[1:0], key[33:2], value[65:34] (72 bits)
//  m_axis   | out | status[1:0], found_value, dropped_key, dropped_value (104)
//  cfg      | in  | probe_limit[7:0]
// one item at a time: the accepting cycle, a hash step, a read step and a
// decide/write step per visited slot (a remove also counts each shifted slot),
// a finish step and the result held in the output register; the registered
// read of the slot memory sets the per-slot cost. after reset a clearing pass
// empties every slot; no item is taken meanwhile. a stall on the result
// register holds the next item.
`default_nettype none
module robin_hood_hash_table_unit #(
    parameter int unsigned SLOTS = rhht_pkg::SLOTS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [71:0]  s_axis_tdata,   // opcode, key, value
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [103:0] m_axis_tdata,   // status, found_value, dropped_key, dropped_value
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [7:0]   i_cfg_data
);
    import rhht_pkg::*;

    localparam int AW = $clog2(SLOTS);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_HASH = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_EV   = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    typedef struct packed {
        logic        used;
        logic [7:0]  pdist;
        logic [31:0] key;
        logic [31:0] data;
    } t_slot;

    t_slot mem [SLOTS];
    t_slot r_rd;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_idx, n_idx, r_prev, n_prev;
    logic [7:0]    r_dist, n_dist, r_limit;
    logic [1:0]    r_op;
    logic [31:0]   r_key, n_key, r_val, n_val;
    logic          r_shift, n_shift;
    logic [1:0]    r_st, n_st;
    logic [31:0]   r_fv, n_fv, r_dk, n_dk, r_dv, n_dv;
    logic          r_ovalid;

    logic          we;
    logic [AW-1:0] waddr;
    t_slot         wdata;
    logic [7:0]    lim;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_dv, r_dk, r_fv, r_st};
    assign lim = (r_limit > DIST_CAP) ? DIST_CAP : r_limit;

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rd <= mem[r_idx];
    end

    always_comb begin
        n_state = r_state; n_idx = r_idx; n_prev = r_prev; n_dist = r_dist;
        n_key = r_key; n_val = r_val; n_shift = r_shift;
        n_st = r_st; n_fv = r_fv; n_dk = r_dk; n_dv = r_dv;
        we = 1'b0; waddr = r_idx; wdata = '0;
        unique case (r_state)
            S_CLR: begin
                we = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == AW'(SLOTS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_axis_tvalid && !r_ovalid) begin
                    n_key = s_axis_tdata[33:2];
                    n_val = s_axis_tdata[65:34];
                    n_dist = '0; n_shift = 1'b0;
                    n_st = ST_OK; n_fv = '0; n_dk = '0; n_dv = '0;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                n_idx = AW'(djb2(r_key));
                n_state = (r_op == OP_SET || r_op == OP_FIND || r_op == OP_REMOVE)
                          ? S_RD : S_DONE;
            end
            S_RD: n_state = S_EV;
            S_EV: begin
                n_state = S_RD;
                n_idx = r_idx + 1'b1;
                if (r_shift) begin
                    // backward shift: move this slot back or stop
                    if (r_rd.used && r_rd.pdist != 8'd0) begin
                        we = 1'b1; waddr = r_prev;
                        wdata = '{1'b1, r_rd.pdist - 8'd1, r_rd.key, r_rd.data};
                        n_prev = r_idx;
                    end else begin
                        we = 1'b1; waddr = r_prev; wdata = '0;
                        n_state = S_DONE;
                    end
                end else if (r_op == OP_SET) begin
                    n_dist = r_dist + 8'd1;
                    if (!r_rd.used || (r_rd.pdist == r_dist && r_rd.key == r_key)) begin
                        we = 1'b1; wdata = '{1'b1, r_dist, r_key, r_val};
                        n_state = S_DONE;
                    end else if (r_dist > lim) begin
                        n_st = ST_OVERFLOW; n_dk = r_key; n_dv = r_val;
                        n_state = S_DONE;
                    end else if (r_dist > r_rd.pdist) begin
                        we = 1'b1; wdata = '{1'b1, r_dist, r_key, r_val};
                        n_key = r_rd.key; n_val = r_rd.data;
                        n_dist = r_rd.pdist + 8'd1;
                    end
                end else begin
                    n_dist = r_dist + 8'd1;
                    if (!r_rd.used || r_dist > r_rd.pdist) begin
                        n_st = ST_NOTFOUND; n_state = S_DONE;
                    end else if (r_rd.pdist == r_dist && r_rd.key == r_key) begin
                        if (r_op == OP_FIND) begin
                            n_fv = r_rd.data; n_state = S_DONE;
                        end else begin
                            n_shift = 1'b1; n_prev = r_idx;
                        end
                    end else if (r_dist == 8'hFF) begin
                        n_st = ST_NOTFOUND; n_state = S_DONE;
                    end
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_idx <= '0; r_limit <= LIMIT_RST; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_idx <= n_idx;
            if (i_cfg_valid) r_limit <= i_cfg_data;
            if (r_state == S_DONE) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev; r_dist <= n_dist; r_key <= n_key; r_val <= n_val;
        r_shift <= n_shift; r_st <= n_st; r_fv <= n_fv; r_dk <= n_dk; r_dv <= n_dv;
        if (r_state == S_IDLE) r_op <= s_axis_tdata[1:0];
    end
endmodule
`default_nettype wire

// ===== rtl/rhht_checker.sv =====
// ----------------------------------------------------------------------------
// rhht_checker: port-level checks for the hash table unit
// Handshake and result-encoding rules seen at the ports.
// ----------------------------------------------------------------------------
`default_nettype none
module rhht_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [103:0] m_axis_tdata
);
    import rhht_pkg::*;

    // one item at a time: no new transaction while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OVERFLOW |-> m_axis_tdata[97:34] == '0)
        else $error("dropped entry nonzero without overflow");
    a_fv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[33:2] == '0)
        else $error("found value nonzero on miss");
endmodule

bind robin_hood_hash_table_unit rhht_checker u_rhht_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// ===== tb/robin_hood_hash_table_unit_test.sv =====
// ----------------------------------------------------------------------------
// robin_hood_hash_table_unit_test: self-checking bench for the hash table unit
// Drives set/find/remove/nop transactions with random gaps and output stalls,
// predicts every result from a local copy of the slot store and compares
// each returned transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module robin_hood_hash_table_unit_test;
    import rhht_pkg::*;

    localparam int NSLOT = 256;
    localparam logic [1:0] OP_NOP = 2'd3;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] key;
        logic [1:0]  opcode;
    } t_cmd;

    typedef struct packed {
        logic [31:0] dropped_value;
        logic [31:0] dropped_key;
        logic [31:0] found_value;
        logic [1:0]  status;
    } t_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [7:0] i_cfg_data = '0;

    robin_hood_hash_table_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predicted table
    logic        tbl_used [NSLOT];
    logic [7:0]  tbl_dist [NSLOT];
    logic [31:0] tbl_key  [NSLOT];
    logic [31:0] tbl_data [NSLOT];
    logic [7:0]  limit_reg;

    t_cmd pending_cmds[$];
    t_rsp expected_rsps[$];
    logic [31:0] live_keys[$];
    int errors = 0;
    int n_sent = 0;
    int n_seen = 0;
    int n_ovf = 0;
    int n_miss = 0;

    function automatic logic [7:0] home_of(input logic [31:0] k);
        logic [31:0] h;
        h = 32'd5381;
        for (int i = 0; i < 4; i++) h = h * 33 + k[8*i +: 8];
        return h[7:0];
    endfunction

    function automatic int find_slot(input logic [31:0] k);
        int idx;
        int d;
        idx = home_of(k);
        d = 0;
        while (tbl_used[idx] && d <= tbl_dist[idx]) begin
            if (tbl_dist[idx] == d && tbl_key[idx] == k) return idx;
            idx = (idx + 1) % NSLOT;
            d++;
        end
        return -1;
    endfunction

    function automatic t_rsp apply_cmd(input t_cmd c);
        t_rsp r;
        int idx;
        int prev;
        int d;
        int lim;
        int td;
        logic [31:0] k;
        logic [31:0] v;
        logic [31:0] t;
        r = '0;
        k = c.key;
        v = c.value;
        case (c.opcode)
            OP_SET: begin
                lim = (limit_reg > DIST_CAP) ? DIST_CAP : limit_reg;
                d = 0;
                idx = home_of(k);
                forever begin
                    if (!tbl_used[idx] || (tbl_dist[idx] == d && tbl_key[idx] == k)) begin
                        tbl_used[idx] = 1'b1;
                        tbl_dist[idx] = d[7:0];
                        tbl_key[idx] = k;
                        tbl_data[idx] = v;
                        break;
                    end
                    if (d > lim) begin
                        r.status = ST_OVERFLOW;
                        r.dropped_key = k;
                        r.dropped_value = v;
                        break;
                    end
                    if (d > tbl_dist[idx]) begin
                        t = tbl_key[idx]; tbl_key[idx] = k; k = t;
                        t = tbl_data[idx]; tbl_data[idx] = v; v = t;
                        td = tbl_dist[idx]; tbl_dist[idx] = d[7:0]; d = td;
                    end
                    d++;
                    idx = (idx + 1) % NSLOT;
                end
            end
            OP_FIND: begin
                idx = find_slot(k);
                if (idx >= 0) r.found_value = tbl_data[idx];
                else r.status = ST_NOTFOUND;
            end
            OP_REMOVE: begin
                idx = find_slot(k);
                if (idx >= 0) begin
                    prev = idx;
                    tbl_used[idx] = 1'b0;
                    idx = (idx + 1) % NSLOT;
                    while (tbl_used[idx] && tbl_dist[idx] != 0) begin
                        tbl_used[prev] = 1'b1;
                        tbl_dist[prev] = tbl_dist[idx] - 8'd1;
                        tbl_key[prev] = tbl_key[idx];
                        tbl_data[prev] = tbl_data[idx];
                        tbl_used[idx] = 1'b0;
                        prev = idx;
                        idx = (idx + 1) % NSLOT;
                    end
                end else begin
                    r.status = ST_NOTFOUND;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // driver
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            expected_rsps.push_back(apply_cmd(t_cmd'(s_axis_tdata[65:0])));
            n_sent++;
            gap_left <= $urandom_range(0, 13) * ($urandom_range(0, 3) != 0);
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid && i_rst_n) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_cmds.size() > 0) begin
                s_axis_tdata <= {6'd0, pending_cmds.pop_front()};
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // monitor
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = t_rsp'(m_axis_tdata[97:0]);
            n_seen++;
            if (got.status == ST_OVERFLOW) n_ovf++;
            if (got.status == ST_NOTFOUND) n_miss++;
            if (expected_rsps.size() == 0) begin
                $error("unexpected result transaction %h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_rsps.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d got %0d", want.status, got.status);
                    errors++;
                end
                if (got.found_value !== want.found_value) begin
                    $error("found_value: expected %h got %h", want.found_value, got.found_value);
                    errors++;
                end
                if (got.dropped_key !== want.dropped_key) begin
                    $error("dropped_key: expected %h got %h", want.dropped_key, got.dropped_key);
                    errors++;
                end
                if (got.dropped_value !== want.dropped_value) begin
                    $error("dropped_value: expected %h got %h",
                           want.dropped_value, got.dropped_value);
                    errors++;
                end
            end
            stall_left <= $urandom_range(0, 13) * ($urandom_range(0, 3) != 0);
            m_axis_tready <= 1'b0;
        end else if (!m_axis_tready) begin
            if (stall_left > 0) stall_left <= stall_left - 1;
            else m_axis_tready <= 1'b1;
        end
    end

    task automatic write_limit(input logic [7:0] lim);
        @(posedge i_clk);
        i_cfg_data <= lim;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        limit_reg = lim;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || s_axis_tvalid || expected_rsps.size() > 0)
            @(posedge i_clk);
    endtask

    function automatic t_cmd make_cmd(input logic [1:0] op, input logic [31:0] k,
                                      input logic [31:0] v);
        t_cmd c;
        c.opcode = op;
        c.key = k;
        c.value = v;
        return c;
    endfunction

    // pick a key: mostly reuse of live keys, else a fresh key from 0..pool or a fully random one
    function automatic logic [31:0] pick_key(input int pool);
        logic [31:0] k;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6 && live_keys.size() > 0) return live_keys[$urandom_range(0, live_keys.size() - 1)];
        if (sel < 8) k = $urandom_range(0, pool);
        else k = $urandom;
        if (live_keys.size() < 400) live_keys.push_back(k);
        return k;
    endfunction

    task automatic run_phase(input int n, input int pool, input int set_pct);
        int r;
        logic [1:0] op;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < set_pct) op = OP_SET;
            else if (r < set_pct + (100 - set_pct) / 2) op = OP_FIND;
            else if (r < 98) op = OP_REMOVE;
            else op = OP_NOP;
            pending_cmds.push_back(make_cmd(op, pick_key(pool), $urandom));
        end
        wait_drained();
    endtask

    initial begin
        logic [7:0] h0;
        int cnt;
        for (int i = 0; i < NSLOT; i++) begin
            tbl_used[i] = 1'b0;
            tbl_dist[i] = '0;
            tbl_key[i] = '0;
            tbl_data[i] = '0;
        end
        limit_reg = LIMIT_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, all opcodes, misses, nop, overflow with the reset limit
        pending_cmds.push_back(make_cmd(OP_FIND, 32'h0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_REMOVE, 32'hFFFF_FFFF, 32'h0));
        pending_cmds.push_back(make_cmd(OP_SET, 32'h0, 32'h8000_0000));
        pending_cmds.push_back(make_cmd(OP_SET, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        pending_cmds.push_back(make_cmd(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(OP_FIND, 32'hFFFF_FFFF, 32'h1234));
        pending_cmds.push_back(make_cmd(OP_FIND, 32'h0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(OP_REMOVE, 32'h0, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(OP_FIND, 32'h0, 32'h0));
        // a pile of keys sharing one home slot to push past the limit
        h0 = home_of(32'd7);
        cnt = 0;
        for (int k = 7; cnt < 12; k++)
            if (home_of(k) == h0) begin
                pending_cmds.push_back(make_cmd(OP_SET, k, k));
                cnt++;
            end
        pending_cmds.push_back(make_cmd(OP_REMOVE, 32'd7, 32'd0));
        pending_cmds.push_back(make_cmd(OP_FIND, 32'd7, 32'd0));
        wait_drained();

        write_limit(8'd0);
        run_phase(250, 2000, 60);
        write_limit(8'd3);
        run_phase(300, 600, 55);
        write_limit(8'd255);
        run_phase(350, 1000, 70);
        write_limit(8'd254);
        run_phase(250, 1000, 40);
        write_limit(8'd1);
        run_phase(350, 400, 50);

        $display("covered %0d commands, %0d results: %0d overflows, %0d misses",
                 n_sent, n_seen, n_ovf, n_miss);
        $display("probe limits 8, 0, 3, 255, 254, 1 with random gaps and stalls");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/rhht_pkg.sv
rtl/robin_hood_hash_table_unit.sv
rtl/rhht_checker.sv
tb/robin_hood_hash_table_unit_test.sv
